// ----- sv/price_level_order_book_core_assert.svh -----
// assertion macros for the price level order book
`ifndef PRICE_LEVEL_ORDER_BOOK_CORE_ASSERT_SVH
`define PRICE_LEVEL_ORDER_BOOK_CORE_ASSERT_SVH
// property a implies property b in the next cycle
`define PLOB_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
// property a implies property b in the same cycle
`define PLOB_ASSERT_NOW(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`endif

// ----- sv/plob_pkg.sv -----
// shared types and constants of the price level order book
package plob_pkg;
  localparam int unsigned BookLevels = 256;
  localparam int unsigned MaxShown = 64;
  localparam int unsigned PriceW = 64;
  localparam int unsigned VolW = 48;
  localparam logic [6:0] DepthReset = 7'd20;

  typedef enum logic [1:0] {
    MODE_UPDATE = 2'd0,
    MODE_UPD_SNAP = 2'd1,
    MODE_SNAP = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  localparam logic [2:0] SideUnknown = 3'd0;
  localparam logic [2:0] SideAsk = 3'd1;
  localparam logic [2:0] SideBestAsk = 3'd2;
  localparam logic [2:0] SideBid = 3'd3;
  localparam logic [2:0] SideBestBid = 3'd4;

  // command broadcast to every cell
  typedef struct packed {
    logic                     write;
    logic                     del;
    logic                     shift;
    logic signed [PriceW-1:0] price;
    logic        [VolW-1:0]   vol;
  } cell_cmd_t;

  // what a cell reports about itself
  typedef struct packed {
    logic valid;
    logic gt;
    logic eq;
  } cell_stat_t;
endpackage

// ----- sv/plob_cell.sv -----
// one level cell: holds a price and volume, compares and shifts with its neighbors
module plob_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  plob_pkg::cell_cmd_t                cmd_i,
  input  logic                               ins_here_i,
  input  logic                               ins_above_i,
  input  logic                               del_above_i,
  input  logic                               left_valid_i,
  input  logic signed [plob_pkg::PriceW-1:0] left_price_i,
  input  logic        [plob_pkg::VolW-1:0]   left_vol_i,
  input  logic                               right_valid_i,
  input  logic signed [plob_pkg::PriceW-1:0] right_price_i,
  input  logic        [plob_pkg::VolW-1:0]   right_vol_i,
  output plob_pkg::cell_stat_t               stat_o,
  output logic signed [plob_pkg::PriceW-1:0] price_o,
  output logic        [plob_pkg::VolW-1:0]   vol_o
);
  import plob_pkg::*;
  logic valid_q, valid_d;
  logic signed [PriceW-1:0] price_q, price_d;
  logic [VolW-1:0] vol_q, vol_d;

  assign stat_o.valid = valid_q;
  assign stat_o.gt = valid_q && (price_q > cmd_i.price);
  assign stat_o.eq = valid_q && (price_q == cmd_i.price);
  assign price_o = price_q;
  assign vol_o = vol_q;

  always_comb begin
    valid_d = valid_q;
    price_d = price_q;
    vol_d = vol_q;
    if (cmd_i.write && stat_o.eq) begin
      vol_d = cmd_i.vol;
    end else if (cmd_i.shift && ins_above_i) begin
      valid_d = left_valid_i;
      price_d = left_price_i;
      vol_d = left_vol_i;
    end else if (cmd_i.shift && ins_here_i) begin
      valid_d = 1'b1;
      price_d = cmd_i.price;
      vol_d = cmd_i.vol;
    end else if (cmd_i.del && del_above_i) begin
      valid_d = right_valid_i;
      price_d = right_price_i;
      vol_d = right_vol_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q <= price_d;
    vol_q <= vol_d;
  end
endmodule

// ----- sv/price_level_order_book_core.sv -----
// top level of the price level order book: cell row, update control, snapshot readout
// an update registers the price add, then the cells compare and shift
// a snapshot then sizes the readout, emits the asks, scans the slots below the asks for bids and
// emits padding items, with a step at each phase change; output stalls hold it up
// sequential: the next item is accepted once the core is back to idle after the previous run
// reset clears running price, level count, cell valid bits and the overflow flag; depth is 20
module price_level_order_book_core #(
  parameter int unsigned BOOK_LEVELS = plob_pkg::BookLevels,
  parameter int unsigned MAX_SHOWN = plob_pkg::MaxShown
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,  // price_delta, volume
  input  logic [1:0]   s_axis_tuser,  // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,  // level_price_out, level_volume_out, shown_count, overflow
  output logic [2:0]   m_axis_tuser,  // side_type
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [6:0]   cfg_data_i
);
  import plob_pkg::*;
  `include "price_level_order_book_core_assert.svh"

  localparam int unsigned CntW = $clog2(BOOK_LEVELS + 1);
  localparam int unsigned IdxW = $clog2(MAX_SHOWN + 1);
  localparam int unsigned WinN = 1 << IdxW;

  typedef enum logic [2:0] {ST_IDLE, ST_UPD, ST_SIZE, ST_ASK, ST_BID, ST_PAD} state_e;

  state_e state_q;
  logic signed [PriceW-1:0] run_q;
  logic [VolW-1:0] vol_q;
  logic [1:0] mode_q;
  logic [CntW-1:0] count_q;
  logic ovf_q;
  logic [6:0] depth_q;
  logic [IdxW-1:0] shown_q, rd_q, emit_q;
  logic first_q;

  cell_cmd_t cmd;
  cell_stat_t stat [BOOK_LEVELS];
  logic signed [PriceW-1:0] cprice [BOOK_LEVELS];
  logic [VolW-1:0] cvol [BOOK_LEVELS];
  logic [BOOK_LEVELS-1:0] ins_here, ins_above, del_above;

  logic any_eq, full;
  logic [IdxW-1:0] shown_d;
  logic [6:0] dsat;

  logic signed [PriceW-1:0] win_price [WinN];
  logic [VolW-1:0] win_vol [WinN];
  logic signed [PriceW-1:0] rp_w;
  logic [VolW-1:0] rv_w;
  logic rd_bid;
  logic [IdxW-1:0] nx;
  logic out_busy;
  logic out_load;
  logic [119:0] out_data;
  logic [2:0] out_side;
  logic out_last;

  always_comb begin
    any_eq = 1'b0;
    for (int i = 0; i < BOOK_LEVELS; i++) any_eq = any_eq | stat[i].eq;
  end
  assign full = (count_q == CntW'(BOOK_LEVELS));

  assign cmd.price = run_q;
  assign cmd.vol = vol_q;
  assign cmd.write = (state_q == ST_UPD) && (mode_q != MODE_SNAP) && (vol_q != '0);
  assign cmd.del = (state_q == ST_UPD) && (mode_q != MODE_SNAP) && (vol_q == '0);
  assign cmd.shift = cmd.write && !any_eq && !full;

  genvar g;
  generate
    for (g = 0; g < BOOK_LEVELS; g++) begin : g_cell
      logic lv, rv;
      logic signed [PriceW-1:0] lp, rp;
      logic [VolW-1:0] lvo, rvo;
      if (g == 0) begin : g_first
        assign ins_here[g] = !stat[g].gt;
        assign ins_above[g] = 1'b0;
        assign del_above[g] = stat[g].eq;
        assign lv = 1'b0;
        assign lp = '0;
        assign lvo = '0;
      end else begin : g_mid
        assign ins_here[g] = stat[g-1].gt && !stat[g].gt;
        assign ins_above[g] = !stat[g-1].gt;
        assign del_above[g] = del_above[g-1] | stat[g].eq;
        assign lv = stat[g-1].valid;
        assign lp = cprice[g-1];
        assign lvo = cvol[g-1];
      end
      if (g == BOOK_LEVELS - 1) begin : g_end
        assign rv = 1'b0;
        assign rp = '0;
        assign rvo = '0;
      end else begin : g_in
        assign rv = stat[g+1].valid;
        assign rp = cprice[g+1];
        assign rvo = cvol[g+1];
      end
      plob_cell u_cell (
        .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd),
        .ins_here_i(ins_here[g]), .ins_above_i(ins_above[g]),
        .del_above_i(del_above[g]),
        .left_valid_i(lv), .left_price_i(lp), .left_vol_i(lvo),
        .right_valid_i(rv), .right_price_i(rp), .right_vol_i(rvo),
        .stat_o(stat[g]), .price_o(cprice[g]), .vol_o(cvol[g])
      );
    end
  endgenerate

  // window over the top cells for the snapshot read
  genvar w;
  generate
    for (w = 0; w < WinN; w++) begin : g_win
      if (w < BOOK_LEVELS) begin : g_cell_win
        assign win_price[w] = cprice[w];
        assign win_vol[w] = cvol[w];
      end else begin : g_zero_win
        assign win_price[w] = '0;
        assign win_vol[w] = '0;
      end
    end
  endgenerate

  assign rp_w = win_price[rd_q];
  assign rv_w = win_vol[rd_q];
  assign rd_bid = rv_w[VolW-1];
  assign nx = rd_q + IdxW'(1);

  always_comb begin
    dsat = (depth_q > 7'(MAX_SHOWN)) ? 7'(MAX_SHOWN) : depth_q;
    if (32'(dsat) > 32'(count_q)) shown_d = IdxW'(count_q);
    else shown_d = IdxW'(dsat);
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_busy = m_axis_tvalid && !m_axis_tready;

  // next output item
  always_comb begin
    out_load = 1'b0;
    out_data = '0;
    out_side = SideUnknown;
    out_last = (emit_q + IdxW'(1)) == shown_q;
    if (!out_busy) begin
      case (state_q)
        ST_ASK: begin
          if (shown_q == '0) begin
            out_load = 1'b1;
            out_data = {ovf_q, 7'd0, {VolW{1'b0}}, {PriceW{1'b0}}};
            out_last = 1'b1;
          end else if (rd_q != shown_q && !rd_bid) begin
            out_load = 1'b1;
            out_data = {ovf_q, 7'(shown_q), rv_w, rp_w};
            out_side = (nx == shown_q || win_vol[nx][VolW-1]) ? SideBestAsk : SideAsk;
          end
        end
        ST_BID: begin
          if (rd_q != shown_q && rd_bid) begin
            out_load = 1'b1;
            out_data = {ovf_q, 7'(shown_q), VolW'(-rv_w), rp_w};
            out_side = first_q ? SideBestBid : SideBid;
          end
        end
        ST_PAD: begin
          if (emit_q != shown_q) begin
            out_load = 1'b1;
            out_data = {ovf_q, 7'(shown_q), {VolW{1'b0}}, {PriceW{1'b0}}};
          end
        end
        default: begin
          out_load = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      run_q <= '0;
      vol_q <= '0;
      count_q <= '0;
      ovf_q <= 1'b0;
      depth_q <= DepthReset;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata <= '0;
      m_axis_tuser <= SideUnknown;
      m_axis_tlast <= 1'b0;
      mode_q <= MODE_UPDATE;
      shown_q <= '0;
      rd_q <= '0;
      emit_q <= '0;
      first_q <= 1'b0;
    end else begin
      if (cfg_valid_i) depth_q <= cfg_data_i;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata <= out_data;
        m_axis_tuser <= out_side;
        m_axis_tlast <= out_last;
        emit_q <= emit_q + IdxW'(1);
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tuser != MODE_NONE) begin
            mode_q <= s_axis_tuser;
            vol_q <= s_axis_tdata[111:64];
            if (s_axis_tuser != MODE_SNAP) run_q <= run_q + s_axis_tdata[63:0];
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (cmd.del && any_eq) count_q <= count_q - CntW'(1);
          if (cmd.shift) count_q <= count_q + CntW'(1);
          if (cmd.write && !any_eq && full) ovf_q <= 1'b1;
          rd_q <= '0;
          emit_q <= '0;
          first_q <= 1'b1;
          if (mode_q == MODE_UPDATE) state_q <= ST_IDLE;
          else state_q <= ST_SIZE;
        end
        ST_SIZE: begin
          shown_q <= shown_d;
          state_q <= ST_ASK;
        end
        ST_ASK: begin
          if (!out_busy) begin
            if (shown_q == '0) begin
              state_q <= ST_IDLE;
            end else if (rd_q == shown_q || rd_bid) begin
              state_q <= ST_BID;
            end else begin
              rd_q <= nx;
            end
          end
        end
        ST_BID: begin
          if (!out_busy) begin
            if (rd_q == shown_q) begin
              state_q <= ST_PAD;
            end else begin
              rd_q <= nx;
              if (rd_bid) first_q <= 1'b0;
            end
          end
        end
        ST_PAD: begin
          if (!out_busy && emit_q == shown_q) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `PLOB_ASSERT_NEXT(a_ovf_sticky, clk_i, rst_ni, ovf_q, ovf_q)
  `PLOB_ASSERT_NOW(a_no_overfill, clk_i, rst_ni, 1'b1, count_q <= CntW'(BOOK_LEVELS))
  `PLOB_ASSERT_NOW(a_idle_ready, clk_i, rst_ni, state_q != ST_IDLE, !s_axis_tready)
endmodule

// ----- test/tb_price_level_order_book_core.sv -----
// testbench for the price level order book core: directed and random feed items, snapshots checked against a book model
`timescale 1ns / 1ps

module tb_price_level_order_book_core;
  import plob_pkg::*;

  typedef struct {
    mode_e              mode;
    logic signed [63:0] delta;
    logic signed [47:0] vol;
  } feed_item_t;

  typedef struct {
    logic [63:0] price;
    logic [47:0] vol;
    logic [2:0]  side;
    logic [6:0]  shown;
    logic        ovf;
    logic        last;
  } slot_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [6:0]   cfg_data_i = '0;

  price_level_order_book_core u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // book shadow
  logic signed [63:0] book_price [BookLevels];
  logic        [47:0] book_vol [BookLevels];
  int unsigned        book_count = 0;
  logic signed [63:0] run_price = '0;
  logic               ovf_seen = 1'b0;
  int unsigned        depth = 32'(DepthReset);

  feed_item_t pending_q[$];
  slot_t      snap_q[$];
  feed_item_t cur_item;
  int         in_gap = 0;
  int         out_gap = 0;
  bit         no_idle = 1'b0;
  int         err_count = 0;

  task automatic report(string what);
    err_count++;
    if (err_count <= 40) $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic book_delete(logic signed [63:0] p);
    for (int i = 0; i < book_count; i++) begin
      if (book_price[i] == p) begin
        for (int j = i; j + 1 < book_count; j++) begin
          book_price[j] = book_price[j+1];
          book_vol[j] = book_vol[j+1];
        end
        book_count--;
        return;
      end
    end
  endtask

  task automatic book_write(logic signed [63:0] p, logic [47:0] v);
    int idx;
    idx = 0;
    while (idx < book_count && book_price[idx] > p) idx++;
    if (idx < book_count && book_price[idx] == p) begin
      book_vol[idx] = v;
      return;
    end
    if (book_count >= BookLevels) begin
      ovf_seen = 1'b1;
      return;
    end
    for (int j = book_count; j > idx; j--) begin
      book_price[j] = book_price[j-1];
      book_vol[j] = book_vol[j-1];
    end
    book_price[idx] = p;
    book_vol[idx] = v;
    book_count++;
  endtask

  task automatic push_slot(logic [63:0] p, logic [47:0] v, logic [2:0] s, int n);
    slot_t sl;
    sl.price = p;
    sl.vol = v;
    sl.side = s;
    sl.shown = n[6:0];
    sl.ovf = ovf_seen;
    sl.last = 1'b0;
    snap_q.push_back(sl);
  endtask

  task automatic apply_feed(feed_item_t it);
    int n, asks, bids, base;
    if (it.mode == MODE_NONE) return;
    if (it.mode != MODE_SNAP) begin
      run_price = run_price + it.delta;
      if (it.vol == 0) book_delete(run_price);
      else book_write(run_price, it.vol);
    end
    if (it.mode == MODE_UPDATE) return;
    n = (depth > MaxShown) ? MaxShown : depth;
    if (n > book_count) n = book_count;
    if (n == 0) begin
      push_slot('0, '0, SideUnknown, 0);
      snap_q[$].last = 1'b1;
      return;
    end
    base = snap_q.size();
    asks = 0;
    while (asks < n && !book_vol[asks][47]) begin
      push_slot(book_price[asks], book_vol[asks], SideAsk, n);
      asks++;
    end
    if (asks > 0) snap_q[base+asks-1].side = SideBestAsk;
    bids = asks;
    for (int i = asks; i < n; i++) begin
      if (book_vol[i][47]) begin
        push_slot(book_price[i], -book_vol[i], SideBid, n);
        bids++;
      end
    end
    if (bids > asks) snap_q[base+asks].side = SideBestBid;
    for (int k = bids; k < n; k++) push_slot('0, '0, SideUnknown, n);
    snap_q[$].last = 1'b1;
  endtask

  // feed driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_feed(cur_item);
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (in_gap > 0) begin
          in_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_item = pending_q.pop_front();
          s_axis_tdata <= {cur_item.vol, cur_item.delta};
          s_axis_tuser <= cur_item.mode;
          s_axis_tvalid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // snapshot monitor
  always @(posedge clk_i or negedge rst_ni) begin
    slot_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (snap_q.size() == 0) begin
          report("snapshot item with nothing expected");
        end else begin
          want = snap_q.pop_front();
          if (m_axis_tdata[63:0] !== want.price)
            report($sformatf("price %h want %h", m_axis_tdata[63:0], want.price));
          if (m_axis_tdata[111:64] !== want.vol)
            report($sformatf("volume %h want %h", m_axis_tdata[111:64], want.vol));
          if (m_axis_tdata[118:112] !== want.shown)
            report($sformatf("shown %0d want %0d", m_axis_tdata[118:112], want.shown));
          if (m_axis_tdata[119] !== want.ovf)
            report($sformatf("overflow %b want %b", m_axis_tdata[119], want.ovf));
          if (m_axis_tuser !== want.side)
            report($sformatf("side %0d want %0d", m_axis_tuser, want.side));
          if (m_axis_tlast !== want.last)
            report($sformatf("last %b want %b", m_axis_tlast, want.last));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  function automatic feed_item_t mk(mode_e m, logic signed [63:0] d, logic signed [47:0] v);
    feed_item_t it;
    it.mode = m;
    it.delta = d;
    it.vol = v;
    return it;
  endfunction

  function automatic feed_item_t rand_feed();
    feed_item_t it;
    int r;
    r = $urandom_range(0, 99);
    it.mode = r < 40 ? MODE_UPDATE : r < 75 ? MODE_UPD_SNAP : r < 93 ? MODE_SNAP : MODE_NONE;
    r = $urandom_range(0, 99);
    if (r < 70) it.delta = 64'($signed($urandom_range(0, 16)) - 8);
    else if (r < 88) it.delta = {$urandom, $urandom};
    else it.delta = '0;
    r = $urandom_range(0, 99);
    if (r < 20) it.vol = '0;
    else if (r < 28) it.vol = $urandom_range(0, 1) ? 48'h7fff_ffff_ffff : 48'h8000_0000_0000;
    else if (r < 60) it.vol = 48'($signed($urandom_range(0, 2000)) - 1000);
    else it.vol = 48'({$urandom, $urandom});
    return it;
  endfunction

  task automatic wait_idle();
    while (pending_q.size() > 0 || s_axis_tvalid || snap_q.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_depth(int unsigned d);
    wait_idle();
    cfg_data_i <= d[6:0];
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    depth = d;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int n);
    repeat (n) pending_q.push_back(rand_feed());
  endtask

  initial begin
    logic signed [47:0] fill_vol;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed
    pending_q.push_back(mk(MODE_SNAP, 64'sd0, 48'sd0));
    pending_q.push_back(mk(MODE_UPD_SNAP, 64'sd100, 48'sh7fff_ffff_ffff));
    pending_q.push_back(mk(MODE_UPDATE, -64'sd5, 48'sd1));
    pending_q.push_back(mk(MODE_UPDATE, -64'sd5, -48'sd1));
    pending_q.push_back(mk(MODE_UPDATE, -64'sd5, 48'sh8000_0000_0000));
    pending_q.push_back(mk(MODE_UPD_SNAP, 64'sd20, 48'sd7));
    pending_q.push_back(mk(MODE_UPD_SNAP, 64'sd0, -48'sd9));
    pending_q.push_back(mk(MODE_UPD_SNAP, -64'sd10, 48'sd0));
    pending_q.push_back(mk(MODE_UPD_SNAP, 64'sd3, 48'sd0));
    pending_q.push_back(mk(MODE_NONE, 64'sd55, 48'sd55));
    pending_q.push_back(mk(MODE_UPD_SNAP, 64'sh7fff_ffff_ffff_ffff, 48'sd3));
    pending_q.push_back(mk(MODE_UPD_SNAP, 64'sh7fff_ffff_ffff_ffff, -48'sd3));
    pending_q.push_back(mk(MODE_UPD_SNAP, 64'sh8000_0000_0000_0000, 48'sd12));
    pending_q.push_back(mk(MODE_UPD_SNAP, -64'sd1, -48'sd2));
    pending_q.push_back(mk(MODE_SNAP, 64'sd0, 48'sd0));
    set_depth(1);
    pending_q.push_back(mk(MODE_SNAP, 64'sd0, 48'sd0));
    random_phase(20);
    set_depth(0);
    random_phase(10);
    set_depth(127);
    random_phase(15);
    no_idle = 1'b1;
    set_depth(64);
    random_phase(15);
    no_idle = 1'b0;
    set_depth($urandom_range(2, 63));
    random_phase(15);
    // fill the table until inserts are refused
    set_depth(64);
    for (int i = 0; i < 260; i++) begin
      fill_vol = 48'($urandom_range(1, 250));
      if (i % 2 != 0) fill_vol = -fill_vol;
      pending_q.push_back(mk((i % 25 == 0) ? MODE_UPD_SNAP : MODE_UPDATE, 64'sd1, fill_vol));
    end
    pending_q.push_back(mk(MODE_SNAP, 64'sd0, 48'sd0));
    random_phase(10);
    wait_idle();
    repeat (40) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/plob_pkg.sv
sv/plob_cell.sv
sv/price_level_order_book_core.sv
test/tb_price_level_order_book_core.sv
